[rtl/sorted_key_table_binary_search_unit_defines.svh]
// Assertion macros for the sorted key table search unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SORTED_KEY_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKTBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKTBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sktbs_pkg.sv]
// Shared types and constants for the sorted key table search unit.
// No dependencies; imported by the controller, datapath and top level.
package sktbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BYTES   = 20;
    localparam int PREFIX_SKIP     = 2;

    // Input field widths
    localparam int REQ_TYPE_W    = 1;
    localparam int ENTRY_INDEX_W = 10;
    localparam int KEY_HIGH_W    = 64;
    localparam int KEY_MIDDLE_W  = 64;
    localparam int KEY_LOW_W     = 32;
    localparam int IN_KEY_W      = KEY_HIGH_W + KEY_MIDDLE_W + KEY_LOW_W;
    localparam int KEY_MAX_W     = 256;

    // Stream bus widths
    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 11;
    localparam int ENTRY_COUNT_W    = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE    = 1'b1;

    // Request kinds
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE  = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic write;   // store the incoming key at entry_index
        logic load;    // latch lookup key and open the search range
        logic probe;   // read the midpoint entry
        logic step;    // narrow the range, or record a hit, from the compare outcome
        logic emit;    // move the search outcome to the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic range_empty;
        logic cmp_eq;
    } status_t;

endpackage

[rtl/sorted_key_table_binary_search_unit.sv]
// Sorted key table with binary-search lookup. Write transactions (tuser 0) store one key
// at entry_index and produce no result. Lookup transactions (tuser 1) search entries 0
// to entry_count-1 (clamped to TABLE_DEPTH) and return found in bit 0 of m_tdata; an
// empty table returns 0. Each probe is one registered read of the key memory followed by
// one compare, and a lookup needs at most floor(log2(entry_count))+1 probes. A lookup that
// misses makes one more visit to the probe state than one that hits, there finding the
// range empty, and no new transaction is taken until the lookup is done. A result waiting
// in the output register does not stop a new transaction from being taken, but the next
// lookup holds in its result state until that result is taken. key_mode 1 ignores the
// two leading key bytes. Entries never written read as undefined. Depends on sktbs_pkg,
// sktbs_ctrl, sktbs_datapath and the defines header.
`include "sorted_key_table_binary_search_unit_defines.svh"

module sorted_key_table_binary_search_unit #(
    parameter int TABLE_DEPTH = sktbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = sktbs_pkg::DEF_KEY_BYTES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sktbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sktbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // entry_index[9:0], key_high[73:10], key_middle[137:74], key_low[169:138], zeros
    input  logic [sktbs_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[0]
    input  logic [sktbs_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // found[0], zeros
    output logic [sktbs_pkg::M_TDATA_W-1:0]       m_tdata
);
    import sktbs_pkg::*;

    localparam int IDX_LSB = 0;
    localparam int HI_LSB  = IDX_LSB + ENTRY_INDEX_W;
    localparam int MID_LSB = HI_LSB + KEY_HIGH_W;
    localparam int LO_LSB  = MID_LSB + KEY_MIDDLE_W;

    cmd_t    cmd;
    status_t status;
    logic    found;

    sktbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[REQ_TYPE_W-1:0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sktbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_index (s_tdata[IDX_LSB +: ENTRY_INDEX_W]),
        .key_high    (s_tdata[HI_LSB +: KEY_HIGH_W]),
        .key_middle  (s_tdata[MID_LSB +: KEY_MIDDLE_W]),
        .key_low     (s_tdata[LO_LSB +: KEY_LOW_W]),
        .cmd         (cmd),
        .status      (status),
        .found       (found)
    );

    assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, found};

    `SKTBS_ASSERT_SAME(a_emit_slot_free, cmd.emit, (!m_tvalid || m_tready), "result overwrote a pending transaction")
    `SKTBS_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "emitted result not presented")
    `SKTBS_ASSERT_NEXT(a_lookup_busy, (s_tvalid && s_tready && (s_tuser[0] == REQ_LOOKUP)), !s_tready, "input taken during a lookup")
    `SKTBS_ASSERT_SAME(a_step_after_probe, cmd.step, $past(cmd.probe), "compare without a preceding probe")

endmodule

[rtl/sktbs_ctrl.sv]
// Search sequencer for the sorted key table search unit.
// Depends on sktbs_pkg for the state enum and the command/status structs.
module sktbs_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic [sktbs_pkg::REQ_TYPE_W-1:0]      req_type,
    output logic                                  s_tready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  sktbs_pkg::status_t                    status,
    output sktbs_pkg::cmd_t                       cmd
);
    import sktbs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (req_type == REQ_LOOKUP))
                    state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (status.range_empty)
                    state_next = ST_RESULT;
                else
                    state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (status.cmp_eq)
                    state_next = ST_RESULT;
                else
                    state_next = ST_PROBE;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.write = s_tvalid && (req_type == REQ_WRITE);
                cmd.load  = s_tvalid && (req_type == REQ_LOOKUP);
            end
            ST_PROBE:   cmd.probe = !status.range_empty;
            ST_COMPARE: cmd.step  = 1'b1;
            ST_RESULT:  cmd.emit  = slot_free;
            default:    cmd       = '0;
        endcase
        // Hold the result until taken, load a new one when emitted
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/sktbs_datapath.sv]
// Key table memory, search range registers and key comparator.
// Depends on sktbs_pkg; driven by commands from sktbs_ctrl.
module sktbs_datapath #(
    parameter int TABLE_DEPTH = sktbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = sktbs_pkg::DEF_KEY_BYTES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sktbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sktbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [sktbs_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  logic [sktbs_pkg::KEY_HIGH_W-1:0]      key_high,
    input  logic [sktbs_pkg::KEY_MIDDLE_W-1:0]    key_middle,
    input  logic [sktbs_pkg::KEY_LOW_W-1:0]       key_low,
    input  sktbs_pkg::cmd_t                       cmd,
    output sktbs_pkg::status_t                    status,
    output logic                                  found
);
    import sktbs_pkg::*;

    localparam int KEY_W    = KEY_BYTES * 8;
    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_CW   = (CNT_W > ENTRY_INDEX_W) ? CNT_W : ENTRY_INDEX_W;
    localparam int CCNT_W   = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;
    localparam int SKIP_W   = ((PREFIX_SKIP < KEY_BYTES) ? PREFIX_SKIP : KEY_BYTES) * 8;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> SKIP_W;

    logic [KEY_W-1:0]         mem [0:TABLE_DEPTH-1];
    logic [KEY_W-1:0]         rd_data_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         hi_reg;    // one past the last candidate
    logic [ADDR_W-1:0]        mid_reg;
    logic                     found_reg;
    logic                     out_found_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     key_mode_reg;

    logic [KEY_MAX_W-1:0]     key_wide;
    logic [KEY_W-1:0]         key_in;
    logic [IDX_CW-1:0]        widx;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     wr_en;
    logic [CCNT_W-1:0]        cnt_ext;
    logic [CNT_W-1:0]         n_sat;
    logic [CNT_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid_comb;
    logic [KEY_W-1:0]         cmp_entry;
    logic [KEY_W-1:0]         cmp_key;
    logic                     cmp_lt;

    // Key bytes past the input fields read as zero
    assign key_wide = {key_high, key_middle, key_low, {(KEY_MAX_W - IN_KEY_W){1'b0}}};
    assign key_in   = key_wide[KEY_MAX_W-1 -: KEY_W];

    assign widx    = IDX_CW'(entry_index);
    assign wr_addr = widx[ADDR_W-1:0];
    assign wr_en   = cmd.write && (widx < IDX_CW'(TABLE_DEPTH));

    // Clamp the programmed count to the table depth
    assign cnt_ext = CCNT_W'(entry_count_reg);
    assign n_sat   = (cnt_ext > CCNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : cnt_ext[CNT_W-1:0];

    // Midpoint of [lo, hi-1]; only used while lo < hi
    assign mid_sum  = ({1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1)) >> 1;
    assign mid_comb = mid_sum[ADDR_W-1:0];

    assign cmp_entry = key_mode_reg ? (rd_data_reg & KEY_MASK) : rd_data_reg;
    assign cmp_key   = key_mode_reg ? (key_reg & KEY_MASK) : key_reg;
    assign cmp_lt    = cmp_entry < cmp_key;

    assign status.range_empty = lo_reg >= hi_reg;
    assign status.cmp_eq      = cmp_entry == cmp_key;
    assign found              = out_found_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= key_in;
        if (cmd.probe)
            rd_data_reg <= mem[mid_comb];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key_in;
            lo_reg    <= '0;
            hi_reg    <= n_sat;
            found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (status.cmp_eq)
                found_reg <= 1'b1;
            else if (cmp_lt)
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
            else
                hi_reg <= CNT_W'(mid_reg);
        end
        if (cmd.probe)
            mid_reg <= mid_comb;
        if (cmd.emit)
            out_found_reg <= found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            key_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[ENTRY_COUNT_W-1:0];
                CFG_KEY_MODE:    key_mode_reg    <= cfg_data[0];
                default:         key_mode_reg    <= key_mode_reg;
            endcase
        end
    end

endmodule
